FILE: rtl/rsc_pkg.sv
// ----------------------------------------------------------------------------
// rsc_pkg: shared definitions for the rpn stack calculator
// Command and status codes, data widths and the control word of a stack cell.
// ----------------------------------------------------------------------------
package rsc_pkg;

    // field widths
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 3;

    // default number of stack entries
    localparam int DEFAULT_STACK_DEPTH = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MUL    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_EQUALS = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FEW     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_INVALID = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_EMPTY   = 3'd4;

    // saturation bounds of a Q16.16 value
    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    // per-cell move control
    typedef struct packed {
        logic shift_down;  // take the neighbor above (push)
        logic shift_up;    // take the neighbor below (pop or combine)
        logic load;        // take the arithmetic result (top cell only)
    } cell_ctrl_t;

endpackage

FILE: rtl/rsc_cell.sv
// ----------------------------------------------------------------------------
// rsc_cell: one stack entry
// Holds one Q16.16 value and, as its control word selects, takes the arithmetic result or a neighbor's value.
// ----------------------------------------------------------------------------
module rsc_cell (
    input  logic                              aclk,
    input  rsc_pkg::cell_ctrl_t               ctrl,
    input  logic signed [rsc_pkg::DATA_W-1:0] above,
    input  logic signed [rsc_pkg::DATA_W-1:0] below,
    input  logic signed [rsc_pkg::DATA_W-1:0] load_data,
    output logic signed [rsc_pkg::DATA_W-1:0] value
);

    logic signed [rsc_pkg::DATA_W-1:0] value_reg;
    logic signed [rsc_pkg::DATA_W-1:0] value_next;

    // pick the source of the entry
    always_comb begin
        value_next = value_reg;
        if (ctrl.load) begin
            value_next = load_data;
        end else if (ctrl.shift_down) begin
            value_next = above;
        end else if (ctrl.shift_up) begin
            value_next = below;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

FILE: rtl/rsc_alu.sv
// ----------------------------------------------------------------------------
// rsc_alu: saturating Q16.16 add and multiply
// The add is combinational; the multiply registers the product, then rounds
// to nearest (ties up) and saturates in the following cycle.
// ----------------------------------------------------------------------------
module rsc_alu (
    input  logic                              aclk,
    input  logic                              mul_start,
    input  logic signed [rsc_pkg::DATA_W-1:0] op_a,
    input  logic signed [rsc_pkg::DATA_W-1:0] op_b,
    output logic signed [rsc_pkg::DATA_W-1:0] sum_sat,
    output logic signed [rsc_pkg::DATA_W-1:0] mul_sat
);

    localparam int W    = rsc_pkg::DATA_W;
    localparam int PW   = 2 * W;
    localparam int FRAC = W / 2;
    localparam int RW   = PW - FRAC;

    logic signed [W:0]      sum_wide;
    logic signed [PW-1:0]   product_reg;
    logic signed [PW-1:0]   product_rnd;
    logic signed [RW-1:0]   shifted;

    // 33-bit sum with clamp on overflow
    always_comb begin
        sum_wide = {op_a[W-1], op_a} + {op_b[W-1], op_b};
        if (sum_wide[W] != sum_wide[W-1]) begin
            sum_sat = sum_wide[W] ? rsc_pkg::Q_MIN : rsc_pkg::Q_MAX;
        end else begin
            sum_sat = sum_wide[W-1:0];
        end
    end

    // full product, registered
    always_ff @(posedge aclk) begin
        if (mul_start) begin
            product_reg <= op_a * op_b;
        end
    end

    // add half an lsb, floor shift, clamp
    always_comb begin
        product_rnd = product_reg + PW'(64'sd1 <<< (FRAC - 1));
        shifted     = product_rnd[PW-1:FRAC];
        if (&shifted[RW-1:W-1] || ~|shifted[RW-1:W-1]) begin
            mul_sat = shifted[W-1:0];
        end else begin
            mul_sat = shifted[RW-1] ? rsc_pkg::Q_MIN : rsc_pkg::Q_MAX;
        end
    end

endmodule

FILE: rtl/rpn_stack_calculator.sv
// ----------------------------------------------------------------------------
// rpn_stack_calculator: reverse-polish evaluator on Q16.16 values
// A row of entry cells forms the stack, top entry in cell 0. Push, pop, add,
// multiply, equals; one result beat per command beat.
//
//   channel | direction | beat contents
//   s_      | in        | tuser: cmd[2:0]; tdata: operand[31:0]
//   m_      | out       | tdata: status, top_value, depth_now, is_empty
//
// push, pop, add, equals and invalid commands write the result register directly; multiply
// goes through the product register, then round and saturate into the top cell.
// s_tready is high in the idle state while the result register is free or
// being drained in the same cycle; a stalled m_ side holds the next command.
// aresetn (synchronous) empties the stack; entry cells are not cleared.
// ----------------------------------------------------------------------------
module rpn_stack_calculator #(
    parameter int STACK_DEPTH = rsc_pkg::DEFAULT_STACK_DEPTH,
    parameter int CW          = $clog2(STACK_DEPTH + 1),
    parameter int OUT_TDATA_W = ((rsc_pkg::STATUS_W + rsc_pkg::DATA_W + CW + 1 + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // command beat
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rsc_pkg::DATA_W-1:0]    s_tdata,   // operand[31:0]
    input  logic [rsc_pkg::CMD_W-1:0]     s_tuser,   // cmd[2:0]
    // result beat
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [OUT_TDATA_W-1:0]        m_tdata    // status, top_value, depth_now, is_empty
);

    localparam int W        = rsc_pkg::DATA_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_MUL  = 1'b1;

    logic                            state_reg, state_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0]          m_tdata_reg;

    logic                            accept;
    logic                            mul_start;
    logic                            out_wr;
    logic                            combine;
    logic                            push;
    logic                            pop;
    logic [rsc_pkg::STATUS_W-1:0]    status;
    logic signed [W-1:0]             top_next;
    logic signed [W-1:0]             top_out;
    logic signed [W-1:0]             sum_sat;
    logic signed [W-1:0]             mul_sat;
    logic signed [W-1:0]             load_data;
    logic signed [W-1:0]             cell_q [STACK_DEPTH];
    rsc_pkg::cell_ctrl_t             cell_ctrl [STACK_DEPTH];

    assign s_tready = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // command decode and stack bookkeeping
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        status     = rsc_pkg::STAT_OK;
        top_next   = cell_q[0];
        mul_start  = 1'b0;
        out_wr     = 1'b0;
        combine    = 1'b0;
        push       = 1'b0;
        pop        = 1'b0;
        load_data  = sum_sat;
        if (state_reg == S_MUL) begin
            combine    = 1'b1;
            load_data  = mul_sat;
            count_next = count_reg - CW'(1);
            top_next   = mul_sat;
            out_wr     = 1'b1;
            state_next = S_IDLE;
        end else if (accept) begin
            out_wr = 1'b1;
            unique case (s_tuser)
                rsc_pkg::CMD_PUSH: begin
                    if (count_reg == CW'(STACK_DEPTH)) begin
                        status = rsc_pkg::STAT_FULL;
                    end else begin
                        push       = 1'b1;
                        count_next = count_reg + CW'(1);
                        top_next   = s_tdata;
                    end
                end
                rsc_pkg::CMD_POP: begin
                    if (count_reg == '0) begin
                        status = rsc_pkg::STAT_EMPTY;
                    end else begin
                        pop        = 1'b1;
                        count_next = count_reg - CW'(1);
                        top_next   = cell_q[1];
                    end
                end
                rsc_pkg::CMD_ADD: begin
                    if (count_reg < CW'(2)) begin
                        status = rsc_pkg::STAT_FEW;
                    end else begin
                        combine    = 1'b1;
                        count_next = count_reg - CW'(1);
                        top_next   = sum_sat;
                    end
                end
                rsc_pkg::CMD_MUL: begin
                    if (count_reg < CW'(2)) begin
                        status = rsc_pkg::STAT_FEW;
                    end else begin
                        mul_start  = 1'b1;
                        out_wr     = 1'b0;
                        state_next = S_MUL;
                    end
                end
                rsc_pkg::CMD_EQUALS: begin
                    status = rsc_pkg::STAT_OK;
                end
                default: begin
                    status = rsc_pkg::STAT_INVALID;
                end
            endcase
        end
    end

    assign top_out = (count_next == '0) ? '0 : top_next;

    // per-cell moves: cell 0 loads the result or the pushed operand, the rest shift down on push and close the gap
    generate
        for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
            if (i == 0) begin : g_top
                assign cell_ctrl[i] = '{shift_down: push, shift_up: pop, load: combine};
                rsc_cell u_cell (
                    .aclk      (aclk),
                    .ctrl      (cell_ctrl[i]),
                    .above     (s_tdata),
                    .below     (cell_q[1]),
                    .load_data (load_data),
                    .value     (cell_q[i])
                );
            end else begin : g_rest
                assign cell_ctrl[i] = '{shift_down: push, shift_up: pop | combine, load: 1'b0};
                rsc_cell u_cell (
                    .aclk      (aclk),
                    .ctrl      (cell_ctrl[i]),
                    .above     (cell_q[i-1]),
                    .below     (cell_q[(i == STACK_DEPTH - 1) ? i : i + 1]),
                    .load_data (load_data),
                    .value     (cell_q[i])
                );
            end
        end
    endgenerate

    rsc_alu u_alu (
        .aclk      (aclk),
        .mul_start (mul_start),
        .op_a      (cell_q[0]),
        .op_b      (cell_q[1]),
        .sum_sat   (sum_sat),
        .mul_sat   (mul_sat)
    );

    // result register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_wr) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_wr) begin
            m_tdata_reg <= OUT_TDATA_W'({(count_next == '0), count_next, top_out, status});
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: rtl/rsc_checker.sv
// ----------------------------------------------------------------------------
// rsc_checker: port-level checks for the rpn stack calculator
// Watches the result beats for consistency of depth, flags and status, and checks the handshake on a stall.
// ----------------------------------------------------------------------------
module rsc_port_checks #(
    parameter int STACK_DEPTH = rsc_pkg::DEFAULT_STACK_DEPTH,
    parameter int CW          = $clog2(STACK_DEPTH + 1),
    parameter int OUT_TDATA_W = ((rsc_pkg::STATUS_W + rsc_pkg::DATA_W + CW + 1 + 7) / 8) * 8
) (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [OUT_TDATA_W-1:0]     m_tdata
);

    localparam int SW = rsc_pkg::STATUS_W;
    localparam int W  = rsc_pkg::DATA_W;

    logic [SW-1:0]  r_status;
    logic [W-1:0]   r_top;
    logic [CW-1:0]  r_depth;
    logic           r_empty;

    assign r_status = m_tdata[SW-1:0];
    assign r_top    = m_tdata[SW+W-1:SW];
    assign r_depth  = m_tdata[SW+W+CW-1:SW+W];
    assign r_empty  = m_tdata[SW+W+CW];

    // empty flag matches depth, and an empty stack shows a zero top
    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (r_empty == (r_depth == '0)) && (!r_empty || r_top == '0))
        else $error("empty flag, depth and top value disagree");

    // popping an empty stack reports depth zero
    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && r_status == rsc_pkg::STAT_EMPTY) |-> r_depth == '0)
        else $error("stack-empty status with nonzero depth");

    // full status only at the bound, and depth never beyond it
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (r_depth <= CW'(STACK_DEPTH)) &&
            (r_status != rsc_pkg::STAT_FULL || r_depth == CW'(STACK_DEPTH)))
        else $error("depth out of range or stack-full status below the bound");

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // no command beat is taken while a result beat is stalled
    a_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !(s_tvalid && s_tready))
        else $error("command beat accepted while result beat stalled");

endmodule

bind rpn_stack_calculator rsc_port_checks #(
    .STACK_DEPTH (STACK_DEPTH),
    .CW          (CW),
    .OUT_TDATA_W (OUT_TDATA_W)
) u_rsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
